### rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/arlmw_pkg.sv
// shared constants, types and functions for the linear mask weight block
package arlmw_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NLANES    = 16;
    localparam int WEIGHT_W  = 24;
    localparam int LOG_W     = FRAC_BITS + 5;
    localparam int BWEIGHT_W = FRAC_BITS + 5;
    localparam int SUM_W     = BWEIGHT_W + 4;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};
    localparam logic [7:0] XT_POLY = 8'h1b;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [3:0] ROW_PERM [16] = '{
        4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9, 4'd14, 4'd3,
        4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1, 4'd6, 4'd11
    };
    localparam logic [1:0] MC_BASE [4] = '{2'd2, 2'd3, 2'd1, 2'd1};

    typedef struct packed {
        logic load;
        logic count;
        logic log_start;
        logic log_step;
        logic acc;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic last_x;
        logic log_last;
        logic last_lane;
    } t_status;

    function automatic logic [7:0] gf_mul(input logic [1:0] c, input logic [7:0] v);
        logic [7:0] t;
        t = {v[6:0], 1'b0} ^ (v[7] ? XT_POLY : 8'h00);
        case (c)
            2'd1:    gf_mul = v;
            2'd2:    gf_mul = t;
            default: gf_mul = t ^ v;
        endcase
    endfunction

    function automatic logic [31:0] mix_unit(input logic [4:0] k);
        logic [1:0]  p;
        logic [7:0]  v;
        logic [31:0] r;
        p = k[4:3];
        v = 8'd1 << k[2:0];
        r = '0;
        for (int i = 0; i < 4; i++) begin
            r[8*i +: 8] = gf_mul(MC_BASE[2'(p - 2'(i))], v);
        end
        return r;
    endfunction

    function automatic logic [31:0] back_mix(input logic [31:0] b);
        logic [31:0] r;
        for (int k = 0; k < 32; k++) begin
            r[k] = ^(mix_unit(5'(k)) & b);
        end
        return r;
    endfunction

endpackage

### rtl/aes_round_linear_mask_weight_top.sv
// top level of the aes round linear mask weight block
// a transfer loads the masks, counts all 256 x values, then runs the log unit and accumulates for each of the 16 lanes
// a start is taken only in idle, so the shared log unit and the x counter serve one transfer at a time
// busy is high from the accepted start until the result strobe
// the result is shown for one cycle with o_valid; the receiver cannot stall
// synchronous active-low reset returns the controller to idle
module aes_round_linear_mask_weight_top import arlmw_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [31:0]         i_in_mask_0,
    input  logic [31:0]         i_in_mask_1,
    input  logic [31:0]         i_in_mask_2,
    input  logic [31:0]         i_in_mask_3,
    input  logic [31:0]         i_out_mask_0,
    input  logic [31:0]         i_out_mask_1,
    input  logic [31:0]         i_out_mask_2,
    input  logic [31:0]         i_out_mask_3,
    output logic                o_valid,
    output logic [WEIGHT_W-1:0] o_weight_sum,
    output logic                o_sign_negative,
    output logic                o_zero_correlation
);
    t_cmd    w_cmd;
    t_status w_status;
    logic    r_valid;

    arlmw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    arlmw_datapath u_dp (
        .i_clk              (i_clk),
        .i_a                ({i_in_mask_3, i_in_mask_2, i_in_mask_1, i_in_mask_0}),
        .i_b                ({i_out_mask_3, i_out_mask_2, i_out_mask_1, i_out_mask_0}),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .o_weight_sum       (o_weight_sum),
        .o_sign_negative    (o_sign_negative),
        .o_zero_correlation (o_zero_correlation)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_cmd.done;
        end
    end

    assign o_valid = r_valid;
endmodule

### rtl/arlmw_ctrl.sv
// controller state machine for the linear mask weight block
module arlmw_ctrl import arlmw_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);
    typedef enum logic [2:0] {S_IDLE, S_COUNT, S_LSTART, S_LSTEP, S_ACC, S_DONE} t_state;
    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_COUNT;
                end
            end
            S_COUNT: begin
                o_cmd.count = 1'b1;
                if (i_status.last_x) n_state = S_LSTART;
            end
            S_LSTART: begin
                o_cmd.log_start = 1'b1;
                n_state         = S_LSTEP;
            end
            S_LSTEP: begin
                o_cmd.log_step = 1'b1;
                if (i_status.log_last) n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_status.last_lane ? S_DONE : S_LSTART;
            end
            S_DONE: begin
                o_cmd.done = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

### rtl/arlmw_datapath.sv
// correlation lanes, log unit and weight accumulator
module arlmw_datapath import arlmw_pkg::*; (
    input  logic                i_clk,
    input  logic [127:0]        i_a,
    input  logic [127:0]        i_b,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    output logic [WEIGHT_W-1:0] o_weight_sum,
    output logic                o_sign_negative,
    output logic                o_zero_correlation
);
    logic [7:0]          r_a [NLANES];
    logic [7:0]          r_b [NLANES];
    logic signed [9:0]   r_cnt [NLANES];
    logic [7:0]          r_x;
    logic [3:0]          r_lane;
    logic [31:0]         r_m;
    logic [LOG_W-1:0]    r_lg;
    logic [4:0]          r_it;
    logic [SUM_W-1:0]    r_sum;
    logic                r_neg;
    logic                r_zero;
    logic [WEIGHT_W-1:0] r_wout;
    logic                r_sout;
    logic                r_zout;

    logic [31:0]       w_d [4];
    logic [7:0]        w_s;
    logic signed [9:0] w_c;
    logic [8:0]        w_n;
    logic [3:0]        w_k;
    logic [63:0]       w_sq;
    logic [63:0]       w_msq;
    logic [BWEIGHT_W-1:0] w_bw;

    always_comb begin
        for (int i = 0; i < 4; i++) w_d[i] = back_mix(i_b[32*i +: 32]);
    end

    assign w_s   = SBOX[r_x];
    assign w_c   = r_cnt[r_lane];
    assign w_n   = w_c[9] ? 9'(-w_c) : w_c[8:0];
    assign w_sq  = r_m * r_m;
    assign w_msq = w_sq >> 31;
    assign w_bw  = BWEIGHT_W'((({{(BWEIGHT_W-4){1'b0}}, 4'd8} << (FRAC_BITS + 1))
                              - BWEIGHT_W'(r_lg) + BWEIGHT_W'(1)) >> 1);

    always_comb begin
        w_k = '0;
        for (int k = 0; k < 9; k++) if (w_n[k]) w_k = 4'(k);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int w = 0; w < 4; w++) begin
                for (int j = 0; j < 4; j++) begin
                    r_a[4*w+j]            <= i_a[32*w + 8*j +: 8];
                    r_b[ROW_PERM[4*w+j]]  <= w_d[w][8*j +: 8];
                end
            end
            for (int l = 0; l < NLANES; l++) r_cnt[l] <= '0;
            r_x    <= '0;
            r_lane <= '0;
            r_sum  <= '0;
            r_neg  <= 1'b0;
            r_zero <= 1'b0;
        end
        if (i_cmd.count) begin
            for (int l = 0; l < NLANES; l++) begin
                r_cnt[l] <= (^((r_a[l] & r_x) ^ (r_b[l] & w_s))) ? r_cnt[l] - 10'sd1
                                                                  : r_cnt[l] + 10'sd1;
            end
            r_x <= r_x + 8'd1;
        end
        if (i_cmd.log_start) begin
            r_m  <= 32'(64'(w_n) << (31 - 32'(w_k)));
            r_lg <= LOG_W'(w_k);
            r_it <= '0;
            if (w_c == 10'sd0) r_zero <= 1'b1;
            if (w_c[9]) r_neg <= ~r_neg;
        end
        if (i_cmd.log_step) begin
            r_it <= r_it + 5'd1;
            if (w_msq[32]) begin
                r_m  <= 32'(w_msq >> 1);
                r_lg <= {r_lg[LOG_W-2:0], 1'b1};
            end else begin
                r_m  <= w_msq[31:0];
                r_lg <= {r_lg[LOG_W-2:0], 1'b0};
            end
        end
        if (i_cmd.acc) begin
            r_sum  <= r_sum + SUM_W'(w_bw);
            r_lane <= r_lane + 4'd1;
        end
        if (i_cmd.done) begin
            r_zout <= r_zero;
            r_sout <= r_zero ? 1'b0 : r_neg;
            if (r_zero) r_wout <= '0;
            else if (r_sum > SUM_W'(WEIGHT_MAX)) r_wout <= WEIGHT_MAX;
            else r_wout <= WEIGHT_W'(r_sum);
        end
    end

    assign o_status.last_x    = (r_x == 8'hff);
    assign o_status.log_last  = (r_it == 5'(FRAC_BITS));
    assign o_status.last_lane = (r_lane == 4'(NLANES - 1));
    assign o_weight_sum       = r_wout;
    assign o_sign_negative    = r_sout;
    assign o_zero_correlation = r_zout;
endmodule

### rtl/arlmw_checker.sv
// port-level checker for the linear mask weight top level
`include "assert_macros.svh"
module arlmw_checker import arlmw_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_valid,
    input logic [WEIGHT_W-1:0] o_weight_sum,
    input logic                o_sign_negative,
    input logic                o_zero_correlation
);
    `ASSERT_IMPL(a_zero_clears, i_clk, i_rst_n, o_valid && o_zero_correlation, o_weight_sum == '0 && !o_sign_negative)
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_IMPL(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    `ASSERT_NEXT(a_valid_single, i_clk, i_rst_n, o_valid, !o_valid)
endmodule

bind aes_round_linear_mask_weight_top arlmw_checker u_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_valid            (o_valid),
    .o_weight_sum       (o_weight_sum),
    .o_sign_negative    (o_sign_negative),
    .o_zero_correlation (o_zero_correlation)
);
